/* src/cat_pkg.sv */
// Shared types and constants for the consensus acceptor table.
// Request and reply item layouts, code enums, controller/datapath handshake.
// No dependencies.
package cat_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_BYTES = 8;

    // Slot remainder unit: 32-bit instance reduced one byte per cycle.
    localparam int MOD_DIGIT_BITS = 8;
    localparam int MOD_STEPS      = 32 / MOD_DIGIT_BITS;
    localparam int MOD_STEP_W     = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        REQ_PREPARE = 2'd0,
        REQ_ACCEPT  = 2'd1,
        REQ_REPEAT  = 2'd2,
        REQ_TRIM    = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        MSG_PROMISE   = 2'd0,
        MSG_ACCEPTED  = 2'd1,
        MSG_PREEMPTED = 2'd2,
        MSG_REPEATED  = 2'd3
    } t_msg_kind;

    typedef struct packed {
        t_req_type   req_type;
        logic [31:0] instance_req;
        logic [31:0] ballot;
        logic [3:0]  value_len;
        logic [63:0] value_data;
    } t_req;

    typedef struct packed {
        t_msg_kind   msg_kind;
        logic [7:0]  out_acceptor;
        logic [31:0] out_instance;
        logic [31:0] out_ballot;
        logic [31:0] out_value_ballot;
        logic [3:0]  out_value_len;
        logic [63:0] out_value_data;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture accepted request
        logic mod_step;  // one byte of the slot remainder
        logic rd;        // read the record at the slot
        logic exec;      // commit table write, trim level and reply
        logic clr_wr;    // clearing pass write
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic reply;
        logic out_free;
    } t_sts;

endpackage

/* src/cat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module cat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cat_ctrl.sv */
// Sequencer for the acceptor: clearing pass, slot reduction, read, update.
// Depends on cat_pkg for the command and status structs.
module cat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cat_pkg::t_sts i_sts,
    output cat_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_READ  = 5'b01000,
        S_EXEC  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [cat_pkg::MOD_STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == cat_pkg::MOD_STEP_W'(cat_pkg::MOD_STEPS - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                // hold until the output register can take a reply
                if (!i_sts.reply || i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* src/cat_dpath.sv */
// Acceptor datapath: request register, slot remainder, record table RAM,
// trim level, acceptor id and the reply register. Uses cat_pkg, cat_ram.
module cat_dpath #(
    parameter int TABLE_DEPTH = cat_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BYTES = cat_pkg::DEF_VALUE_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  cat_pkg::t_req i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cat_pkg::t_rsp o_out_item,
    input  cat_pkg::t_cmd i_cmd,
    output cat_pkg::t_sts o_sts
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int VW    = VALUE_BYTES * 8;
    localparam int REC_W = 1 + 32 + 8 + 32 + 32 + 4 + VW;
    localparam logic [3:0] VB4 = 4'(VALUE_BYTES);

    cat_pkg::t_req  r_req;
    logic [31:0]    r_shift;
    logic [AW-1:0]  r_rem, n_rem;
    logic [AW-1:0]  r_clr_addr;
    logic [31:0]    r_trim;
    logic [7:0]     r_acc_id;
    logic           r_out_valid;
    cat_pkg::t_rsp  r_out_item, n_out_item;

    // Slot = instance mod TABLE_DEPTH, one byte per step, restoring.
    always_comb begin
        logic [AW:0] t;
        n_rem = r_rem;
        for (int b = 0; b < cat_pkg::MOD_DIGIT_BITS; b++) begin
            t = {n_rem, r_shift[31 - b]};
            if (t >= (AW + 1)'(TABLE_DEPTH)) begin
                t = t - (AW + 1)'(TABLE_DEPTH);
            end
            n_rem = t[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_in_item;
            r_shift <= i_in_item.instance_req;
            r_rem   <= '0;
        end else if (i_cmd.mod_step) begin
            r_shift <= r_shift << cat_pkg::MOD_DIGIT_BITS;
            r_rem   <= n_rem;
        end
    end

    // Record table
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata, ram_rdata;

    logic          rd_valid;
    logic [31:0]   rd_inst, rd_bal, rd_vbal;
    logic [7:0]    rd_acc;
    logic [3:0]    rd_vlen;
    logic [VW-1:0] rd_val;

    assign {rd_valid, rd_inst, rd_acc, rd_bal, rd_vbal, rd_vlen, rd_val} = ram_rdata;

    cat_ram #(
        .WIDTH(REC_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(r_rem),
        .o_rdata(ram_rdata)
    );

    // Saturated length and byte-masked value of an accept
    logic [3:0]    vlen_sat;
    logic [VW-1:0] vmask;

    always_comb begin
        vlen_sat = (r_req.value_len > VB4) ? VB4 : r_req.value_len;
        for (int i = 0; i < VALUE_BYTES; i++) begin
            vmask[i*8 +: 8] = (4'(i) < vlen_sat) ? r_req.value_data[i*8 +: 8] : 8'h00;
        end
    end

    // Request evaluation against the stored record
    logic          above, found, upd;
    logic          wr, reply, trim_upd;
    logic [31:0]   w_vbal;
    logic [3:0]    w_vlen;
    logic [VW-1:0] w_val;
    cat_pkg::t_msg_kind s_kind;
    logic [7:0]    s_acc;
    logic [31:0]   s_bal, s_vbal;
    logic [3:0]    s_vlen;
    logic [VW-1:0] s_val;

    always_comb begin
        above    = r_req.instance_req > r_trim;
        found    = above && rd_valid && (rd_inst == r_req.instance_req);
        upd      = !found || (rd_bal <= r_req.ballot);
        wr       = 1'b0;
        reply    = 1'b0;
        trim_upd = 1'b0;
        w_vbal   = found ? rd_vbal : 32'd0;
        w_vlen   = found ? rd_vlen : 4'd0;
        w_val    = found ? rd_val : '0;
        s_kind   = cat_pkg::MSG_PROMISE;
        s_acc    = rd_acc;
        s_bal    = rd_bal;
        s_vbal   = rd_vbal;
        s_vlen   = rd_vlen;
        s_val    = rd_val;
        case (r_req.req_type)
            cat_pkg::REQ_PREPARE: begin
                if (above) begin
                    reply = 1'b1;
                    wr    = upd;
                    if (upd) begin
                        s_acc  = r_acc_id;
                        s_bal  = r_req.ballot;
                        s_vbal = w_vbal;
                        s_vlen = w_vlen;
                        s_val  = w_val;
                    end
                end
            end
            cat_pkg::REQ_ACCEPT: begin
                if (above) begin
                    reply = 1'b1;
                    if (upd) begin
                        wr     = 1'b1;
                        w_vbal = r_req.ballot;
                        w_vlen = vlen_sat;
                        w_val  = vmask;
                        s_kind = cat_pkg::MSG_ACCEPTED;
                        s_acc  = r_acc_id;
                        s_bal  = r_req.ballot;
                        s_vbal = r_req.ballot;
                        s_vlen = vlen_sat;
                        s_val  = vmask;
                    end else begin
                        // preempted: stored ballot only, no value
                        s_kind = cat_pkg::MSG_PREEMPTED;
                        s_acc  = r_acc_id;
                        s_vbal = 32'd0;
                        s_vlen = 4'd0;
                        s_val  = '0;
                    end
                end
            end
            cat_pkg::REQ_REPEAT: begin
                if (found && (rd_vlen != 4'd0)) begin
                    reply  = 1'b1;
                    s_kind = cat_pkg::MSG_REPEATED;
                end
            end
            cat_pkg::REQ_TRIM: begin
                trim_upd = above;
            end
            default: begin
                reply = 1'b0;
            end
        endcase

        n_out_item.msg_kind         = s_kind;
        n_out_item.out_acceptor     = s_acc;
        n_out_item.out_instance     = r_req.instance_req;
        n_out_item.out_ballot       = s_bal;
        n_out_item.out_value_ballot = s_vbal;
        n_out_item.out_value_len    = s_vlen;
        n_out_item.out_value_data   = 64'(s_val);
    end

    // Table write: clearing pass or commit of an update
    always_comb begin
        if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_cmd.exec && wr;
            ram_waddr = r_rem;
            ram_wdata = {1'b1, r_req.instance_req, r_acc_id, r_req.ballot,
                         w_vbal, w_vlen, w_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_trim      <= 32'd0;
            r_acc_id    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec && trim_upd) begin
                r_trim <= r_req.instance_req;
            end
            if (i_cfg_we) begin
                r_acc_id <= i_cfg_data;
            end
            if (i_cmd.exec && reply) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && reply) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == AW'(TABLE_DEPTH - 1));
    assign o_sts.reply    = reply;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/consensus_acceptor_table.sv */
// Flow: an accepted request passes the byte-serial slot remainder, one table
// read and one update before its reply is registered; a stalled output delays it.
// A new item is taken only once the last one is through, set by the byte-serial
// slot unit and the single read-then-write pass over the record RAM.
// Reset: synchronous; a clearing pass writes every table entry to zero while
// input stall is high. Trim level and acceptor id reset to 0.
module consensus_acceptor_table #(
    parameter int TABLE_DEPTH = cat_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_BYTES = cat_pkg::DEF_VALUE_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cat_pkg::t_req i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cat_pkg::t_rsp o_out_item
);

    cat_pkg::t_cmd cmd;
    cat_pkg::t_sts sts;

    cat_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    cat_dpath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_BYTES(VALUE_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

/* src/cat_chk.sv */
// Port-level checks for consensus_acceptor_table, attached by bind.
// Depends on cat_pkg for item types and reply codes.
module cat_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input cat_pkg::t_rsp o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("reply dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("stalled reply changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("not in clearing pass after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_preempt_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.msg_kind == cat_pkg::MSG_PREEMPTED))
        |-> (o_out_item.out_value_len == 4'd0 && o_out_item.out_value_data == 64'd0
             && o_out_item.out_value_ballot == 32'd0))
        else $error("preempted reply carries a value");

endmodule

bind consensus_acceptor_table cat_chk u_cat_chk (.*);
